// ===== rtl/core/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg
// shared types and constants of the random permutation shuffler
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

	// fixed field widths
	localparam int POS_W   = 10;
	localparam int RAND_W  = 31;
	localparam int COUNT_W = 11;

	// input mode codes
	localparam logic MODE_WORD    = 1'b0;
	localparam logic MODE_RESTART = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [RAND_W-1:0] random_word;
	} rps_in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] item_index;
		logic             last;
	} rps_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIV,
		ST_CHECK,
		ST_RD_A,
		ST_RD_B,
		ST_WR_A,
		ST_WR_B,
		ST_EMIT,
		ST_RD_Z,
		ST_EMIT_Z,
		ST_EMIT_ONE
	} rps_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/random_permutation_shuffler.sv =====
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// fisher-yates permutation generator driven by external random words
// ----------------------------------------------------------------------------
// A restart word (mode 1) starts a shuffle of item_count entries (saturated
// to MAX_ITEMS). A count of zero gives nothing, a count of one gives slot 0
// at once, and a larger count first sweeps the table ram to clear the
// written marks of entries 0 to count-1, one entry a cycle. For each later
// random word, the remainder by position+1 comes from a restoring remainder
// unit that retires one dividend bit per cycle, followed by a rejection
// check and a two-read, two-write swap through the table ram, which has one
// write port and one read port. A rejected word gives nothing; an accepted
// one gives the slot just fixed, and at slot 1 also slot 0 marked last.
// Words that arrive with no shuffle in progress are taken and dropped. The
// input is stalled while a word is in work; results leave through an output
// register so the next word can be taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module random_permutation_shuffler
	import rps_pkg::*;
#(
	parameter int MAX_ITEMS = 1024,
	parameter int RAND_BITS = 31
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_W-1:0] cfg_wr_data,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire rps_in_t            in_word,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      rps_out_t           out_word
);

	localparam int IDX_W  = $clog2(MAX_ITEMS);
	localparam int SPAN_W = $clog2(MAX_ITEMS + 1);
	localparam int CHK_W  = ((RAND_BITS > SPAN_W) ? RAND_BITS : SPAN_W) + 2;

	// control state
	rps_state_t         state_q, state_d;
	logic               active_q;
	logic [COUNT_W-1:0] item_count_q;
	logic               out_valid_q;

	// working registers
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     clr_q;
	logic [IDX_W-1:0]     j_q;
	logic [IDX_W-1:0]     a_q;
	logic [IDX_W-1:0]     b_q;
	logic [RAND_BITS-1:0] word_q;
	rps_out_t             out_q;

	// combinational
	logic                 in_acc;
	logic                 is_restart;
	logic [SPAN_W-1:0]    count_sat;
	logic [SPAN_W-1:0]    span;
	logic [RAND_BITS-1:0] word_in;
	logic                 div_start;
	logic                 div_done;
	logic [SPAN_W-1:0]    rem;
	logic [CHK_W-1:0]     chk_sum;
	logic                 reject;
	logic                 can_load;
	logic                 out_load;
	rps_out_t             out_d;

	// table ram: {written mark, entry}
	logic             ram_wr_en;
	logic [IDX_W-1:0] ram_wr_addr;
	logic [IDX_W:0]   ram_wr_data;
	logic             ram_rd_en;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [IDX_W:0]   ram_rd_data;
	logic [IDX_W-1:0] val_a;
	logic [IDX_W-1:0] val_b;
	logic [IDX_W-1:0] val_z;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = state_q != ST_IDLE;
	assign is_restart = in_word.mode == MODE_RESTART;
	assign word_in    = RAND_BITS'(in_word.random_word);

	// count saturates at capacity
	assign count_sat = (32'(item_count_q) > 32'(MAX_ITEMS)) ? SPAN_W'(MAX_ITEMS)
		: SPAN_W'(item_count_q);
	assign span = SPAN_W'(pos_q) + SPAN_W'(1);

	// word is rejected when the multiple of span below it plus span
	// runs past the top of the random range
	assign chk_sum = CHK_W'(word_q) + CHK_W'(span) - CHK_W'(rem);
	assign reject  = chk_sum >= (CHK_W'(1) << RAND_BITS);

	// an entry with a clear mark reads as its own index
	assign val_a = ram_rd_data[IDX_W] ? ram_rd_data[IDX_W-1:0] : pos_q;
	assign val_b = ram_rd_data[IDX_W] ? ram_rd_data[IDX_W-1:0] : j_q;
	assign val_z = ram_rd_data[IDX_W] ? ram_rd_data[IDX_W-1:0] : IDX_W'(0);

	assign can_load = !out_valid_q || !out_stall;

	rps_rem_unit #(
		.DVD_W(RAND_BITS),
		.DVS_W(SPAN_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (word_in),
		.divisor  (span),
		.done     (div_done),
		.remainder(rem)
	);

	rps_ram #(
		.WIDTH(IDX_W + 1),
		.DEPTH(MAX_ITEMS)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (is_restart) begin
						if (count_sat >= SPAN_W'(2)) begin
							state_d = ST_CLEAR;
						end else if (count_sat == SPAN_W'(1)) begin
							state_d = ST_EMIT_ONE;
						end
					end else if (active_q) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_CLEAR: begin
				if (clr_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = reject ? ST_IDLE : ST_RD_A;
			ST_RD_A:   state_d = ST_RD_B;
			ST_RD_B:   state_d = ST_WR_A;
			ST_WR_A:   state_d = ST_WR_B;
			ST_WR_B:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (can_load) begin
					state_d = (pos_q == IDX_W'(1)) ? ST_RD_Z : ST_IDLE;
				end
			end
			ST_RD_Z:   state_d = ST_EMIT_Z;
			ST_EMIT_Z: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_ONE: begin
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_start   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = pos_q;
		ram_wr_data = {1'b1, val_b};
		ram_rd_en   = 1'b0;
		ram_rd_addr = pos_q;
		out_load    = 1'b0;
		out_d       = '{position: '0, item_index: '0, last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				div_start = in_acc && !is_restart && active_q;
			end
			ST_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '0;
			end
			ST_RD_A: begin
				ram_rd_en = 1'b1;
			end
			ST_RD_B: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = j_q;
			end
			ST_WR_A: begin
				ram_wr_en = 1'b1;
			end
			ST_WR_B: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = j_q;
				ram_wr_data = {1'b1, a_q};
			end
			ST_EMIT: begin
				out_load = can_load;
				out_d    = '{position: POS_W'(pos_q), item_index: POS_W'(b_q), last: 1'b0};
			end
			ST_RD_Z: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = '0;
			end
			ST_EMIT_Z: begin
				out_load = can_load;
				out_d    = '{position: '0, item_index: POS_W'(val_z), last: 1'b1};
			end
			ST_EMIT_ONE: begin
				out_load = can_load;
				out_d    = '{position: '0, item_index: '0, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= 1'b0;
			item_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				item_count_q <= cfg_wr_data;
			end
			if (state_q == ST_IDLE && in_acc && is_restart) begin
				active_q <= count_sat >= SPAN_W'(2);
			end else if (state_q == ST_EMIT && can_load && pos_q == IDX_W'(1)) begin
				active_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			word_q <= word_in;
			if (is_restart) begin
				pos_q <= IDX_W'(count_sat - SPAN_W'(1));
				clr_q <= IDX_W'(count_sat - SPAN_W'(1));
			end
		end
		if (state_q == ST_CLEAR) begin
			clr_q <= clr_q - IDX_W'(1);
		end
		if (state_q == ST_CHECK) begin
			j_q <= IDX_W'(rem);
		end
		if (state_q == ST_RD_B) begin
			a_q <= val_a;
		end
		if (state_q == ST_WR_A) begin
			b_q <= val_b;
		end
		if (state_q == ST_EMIT && can_load && pos_q != IDX_W'(1)) begin
			pos_q <= pos_q - IDX_W'(1);
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/rps_ram.sv =====
// ----------------------------------------------------------------------------
// rps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rps_rem_unit.sv =====
// ----------------------------------------------------------------------------
// rps_rem_unit
// iterative restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rps_rem_unit #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output      logic             done,
	output      logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;

	// shift in the next dividend bit and subtract when it fits
	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the random permutation shuffler. A behavioral
// model of the fisher-yates draw runs alongside the block and predicts
// every fixed slot. The run starts with directed corner cases, then drives
// random shuffles with idle gaps on the input and stall gaps on the output.
// ----------------------------------------------------------------------------

module tb
	import rps_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SLOTS      = 1024;
	localparam int SETTLE_CYCLES  = 1200;   // longest restart sweep plus one draw
	localparam int WATCHDOG_LIMIT = 20000;  // cycles with no word moving on any channel
	localparam int RANDOM_ITEMS   = 500;
	localparam int IDLE_PERCENT   = 37;
	localparam logic [RAND_W-1:0] WORD_ALL_ONES = '1;

	// dut signals
	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	rps_in_t            in_word;
	logic               out_valid;
	logic               out_stall = 1'b0;
	rps_out_t           out_word;

	random_permutation_shuffler #(
		.MAX_ITEMS(MAX_SLOTS),
		.RAND_BITS(RAND_W)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word)
	);

	always #5 clk = ~clk;

	// shadow copy of the shuffle state
	logic [POS_W-1:0] model_table [MAX_SLOTS];
	bit               model_marked [MAX_SLOTS];
	int unsigned      model_pos;
	int unsigned      model_count;
	bit               model_running;

	// slots the block still owes us, oldest first
	rps_out_t pending_slots [$];

	int errors = 0;
	int words_sent;
	int restarts_sent;
	int draws_rejected;
	int results_seen = 0;
	int settings_used;
	int idle_cycles = 0;

	bit steady;    // no idling on either side while set
	bit lockstep;  // sender waits for every owed slot after each word

	// an unmarked entry reads as its own index
	function automatic logic [POS_W-1:0] slot_entry(int unsigned k);
		return model_marked[k] ? model_table[k] : POS_W'(k);
	endfunction

	function automatic rps_out_t make_slot(int unsigned p, logic [POS_W-1:0] idx, logic lst);
		rps_out_t s;
		s.position   = POS_W'(p);
		s.item_index = idx;
		s.last       = lst;
		return s;
	endfunction

	function automatic rps_in_t draw(logic [RAND_W-1:0] v);
		rps_in_t w;
		w.mode        = MODE_WORD;
		w.random_word = v;
		return w;
	endfunction

	// restart payload bits are don't-care, so keep them moving
	function automatic rps_in_t restart_word();
		rps_in_t w;
		w.mode        = MODE_RESTART;
		w.random_word = RAND_W'($urandom);
		return w;
	endfunction

	// advance the shadow shuffle by one accepted word and queue its slots
	task automatic shuffle_step(rps_in_t w);
		longint unsigned rmax;
		longint unsigned span;
		longint unsigned lim;
		longint unsigned wv;
		int unsigned     cnt;
		int unsigned     j;
		logic [POS_W-1:0] a;
		logic [POS_W-1:0] b;
		rmax = 64'h7FFF_FFFF;
		if (w.mode == MODE_RESTART) begin
			cnt = (model_count > MAX_SLOTS) ? MAX_SLOTS : model_count;
			foreach (model_marked[k]) model_marked[k] = 1'b0;
			model_running = 1'b0;
			model_pos     = 0;
			if (cnt == 1) begin
				pending_slots.push_back(make_slot(0, '0, 1'b1));
			end else if (cnt > 1) begin
				model_pos     = cnt - 1;
				model_running = 1'b1;
			end
		end else if (model_running) begin
			span = model_pos + 1;
			lim  = rmax - rmax % span;
			wv   = w.random_word;
			if (wv >= lim) begin
				// biased tail of the word range, draw again
				draws_rejected++;
			end else begin
				j = 32'(wv % span);
				a = slot_entry(model_pos);
				b = slot_entry(j);
				model_table[model_pos]  = b;
				model_marked[model_pos] = 1'b1;
				model_table[j]          = a;
				model_marked[j]         = 1'b1;
				if (model_pos == 1) begin
					// last draw fixes slot 1 and leaves slot 0 final too
					pending_slots.push_back(make_slot(1, model_table[1], 1'b0));
					pending_slots.push_back(make_slot(0, slot_entry(0), 1'b1));
					model_running = 1'b0;
					model_pos     = 0;
				end else begin
					pending_slots.push_back(make_slot(model_pos, model_table[model_pos], 1'b0));
					model_pos--;
				end
			end
		end
	endtask

	// offer one word, wait for the handshake, then predict; ends at a falling edge
	task automatic send_word(rps_in_t w);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		shuffle_step(w);
		if (w.mode == MODE_RESTART)
			restarts_sent++;
		else
			words_sent++;
		@(negedge clk);
		if (lockstep) begin
			// hold off until the block has paid every slot
			in_valid <= 1'b0;
			do @(negedge clk); while (pending_slots.size() != 0);
		end
	endtask

	// input quiet, all slots in, and a restart sweep or last draw has had time to end
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_slots.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_count(int unsigned v);
		drain_and_settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= COUNT_W'(v);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		model_count = v & 32'h7FF;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// count is zero out of reset: draws are dropped, restart gives nothing
	task automatic test_idle_after_reset();
		send_word(draw('0));
		send_word(draw(WORD_ALL_ONES));
		send_word(restart_word());
		send_word(draw(31'h2AAA_AAAA));
	endtask

	// a one-item shuffle is done at restart
	task automatic test_single_item();
		set_count(1);
		send_word(restart_word());
		send_word(draw('0));
	endtask

	// smallest real shuffle: all-ones is always rejected, then one draw ends it
	task automatic test_two_items();
		set_count(2);
		send_word(restart_word());
		send_word(draw(WORD_ALL_ONES));
		send_word(draw(31'h5555_5555));
		send_word(draw('0));
	endtask

	// a restart in the middle throws away the shuffle in progress
	task automatic test_restart_midway();
		set_count(3);
		send_word(restart_word());
		send_word(draw(31'd1));
		send_word(restart_word());
		send_word(draw('0));
		send_word(draw(WORD_ALL_ONES - 1));  // above the limit at span two
		send_word(draw(31'd7));
	endtask

	// oversized count saturates to the table size, plus the exact full size
	task automatic test_capacity();
		set_count(2047);
		send_word(restart_word());
		send_word(draw(31'h7FFF_FBFF));      // just under the limit at span 1024
		send_word(draw(31'h7FFF_FC00));
		send_word(draw(31'h7FFF_FFFE));
		set_count(1024);
		send_word(restart_word());
		send_word(draw(31'h5555_5555));
		send_word(draw(WORD_ALL_ONES));
		send_word(draw(31'h2AAA_AAAA));
	endtask

	// one whole shuffle with the sender waiting out every result
	task automatic test_lockstep();
		lockstep = 1'b1;
		set_count(6);
		send_word(restart_word());
		while (model_running) send_word(draw(RAND_W'($urandom)));
		lockstep = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// random shuffles: mostly full restart-and-draw runs, some noise
	// ------------------------------------------------------------------
	task automatic test_random_shuffles();
		int      sent;
		int      phase;
		int      r;
		int      n;
		int      runs;
		rps_in_t w;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			// a few phases in a row with both sides never idling
			steady = (phase >= 4 && phase < 9);
			r = $urandom_range(0, 99);
			if (r < 3)
				set_count($urandom_range(0, 1));
			else if (r < 6)
				set_count($urandom_range(1024, 2047));
			else
				set_count($urandom_range(2, 20));
			runs = $urandom_range(1, 3);
			repeat (runs) begin
				send_word(restart_word());
				sent++;
				n = 0;
				while (model_running && n < 40) begin
					r = $urandom_range(0, 99);
					if (r < 3)
						break;  // leave it unfinished, the next restart drops it
					else if (r < 11)
						w = draw(WORD_ALL_ONES - RAND_W'($urandom_range(0, 31)));
					else
						w = draw(RAND_W'($urandom));
					send_word(w);
					sent++;
					n++;
				end
				// stray draws after the shuffle ended
				if (!model_running && $urandom_range(0, 3) == 0)
					send_word(draw(RAND_W'($urandom)));
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// receiver: random stall, checked at the rising edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	always @(posedge clk) begin
		rps_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_slots.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got pos %0d item %0d last %0b",
					$time, out_word.position, out_word.item_index, out_word.last);
			end else begin
				want = pending_slots.pop_front();
				results_seen++;
				if (out_word.position !== want.position) begin
					errors++;
					$display("%0t: position mismatch, expected %0d, got %0d",
						$time, want.position, out_word.position);
				end
				if (out_word.item_index !== want.item_index) begin
					errors++;
					$display("%0t: item_index mismatch at pos %0d, expected %0d, got %0d",
						$time, want.position, want.item_index, out_word.item_index);
				end
				if (out_word.last !== want.last) begin
					errors++;
					$display("%0t: last mismatch at pos %0d, expected %0b, got %0b",
						$time, want.position, want.last, out_word.last);
				end
			end
		end
	end

	// watchdog: any word moving on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_word     = '0;
		words_sent     = 0;
		restarts_sent  = 0;
		draws_rejected = 0;
		settings_used  = 0;
		steady         = 1'b0;
		lockstep       = 1'b0;
		model_count    = 0;
		model_pos      = 0;
		model_running  = 1'b0;
		foreach (model_marked[k]) model_marked[k] = 1'b0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_idle_after_reset();
		test_single_item();
		test_two_items();
		test_restart_midway();
		test_capacity();
		test_lockstep();
		test_random_shuffles();

		// let the last slots drain and any trailing sweep finish
		drain_and_settle();

		$display("tb: %0d draw words (%0d rejected) and %0d restarts over %0d count settings",
			words_sent, draws_rejected, restarts_sent, settings_used);
		$display("tb: %0d fixed slots compared, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== random_permutation_shuffler.f =====
rtl/core/rps_pkg.sv
rtl/core/rps_ram.sv
rtl/core/rps_rem_unit.sv
rtl/core/random_permutation_shuffler.sv
test/tb.sv
